/* rtl/vqpb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the VOQ/VIQ pause buffer.
// No dependencies; imported by voq_viq_pause_buffer.
package vqpb_pkg;

  localparam int MAX_PORTS   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int DESC_WIDTH  = 16;

  localparam int PORT_W  = 3;                          // src / dst field width
  localparam int PIU_W   = 4;                          // ports_in_use width
  localparam int LVL_W   = 5;                          // pause / resume level width
  localparam int OCC_W   = 5;                          // reported occupancy width
  localparam int DOUT_W  = 16;                         // descriptor field width
  localparam int PAIRS   = MAX_PORTS * MAX_PORTS;
  localparam int QUEUES  = 2 * PAIRS;
  localparam int PAIR_W  = $clog2(PAIRS);
  localparam int QADDR_W = $clog2(QUEUES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int DADDR_W = QADDR_W + PTR_W;

  // operation kinds
  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_XFER = 2'd1;
  localparam logic [1:0] KIND_DEQ  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_SAME   = 3'd1;
  localparam logic [2:0] ST_PAUSED = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;
  localparam logic [2:0] ST_RANGE  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_VOQ_PAUSE  = 3'd0;
  localparam logic [2:0] CFG_VOQ_RESUME = 3'd1;
  localparam logic [2:0] CFG_VIQ_PAUSE  = 3'd2;
  localparam logic [2:0] CFG_VIQ_RESUME = 3'd3;
  localparam logic [2:0] CFG_PORTS      = 3'd4;

  // per-queue bookkeeping; flag is the upstream flag on a VOQ entry and the
  // transfer flag on a VIQ entry
  typedef struct packed {
    logic             flag;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] cnt;
  } qent_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RVIQ = 5'b00010,
    S_EXEC = 5'b00100,
    S_MOVE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  function automatic logic hyst(input logic flag, input logic [CNT_W-1:0] cnt,
                                input logic [LVL_W-1:0] pause,
                                input logic [LVL_W-1:0] resume);
    logic res;
    if (!flag) res = (LVL_W + 1)'(cnt) >= (LVL_W + 1)'(pause);
    else       res = !((LVL_W + 1)'(cnt) < (LVL_W + 1)'(resume));
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
    logic [PTR_W-1:0] res;
    if (i == PTR_W'(QUEUE_DEPTH - 1)) res = '0;
    else                             res = i + 1'b1;
    return res;
  endfunction

  function automatic logic q_full(input logic [CNT_W-1:0] cnt);
    return cnt >= CNT_W'(QUEUE_DEPTH);
  endfunction

endpackage

/* rtl/voq_viq_pause_buffer.sv */
`timescale 1ns / 1ps
// A rejected pair goes straight to the output step; other words pass the read, execute
// and output steps, a VOQ-to-VIQ transfer also a move step. The queue-state memory is
// read twice (VOQ entry, then VIQ entry), then written up to twice; words are taken one
// at a time. in_ready is low while a word is in flight or its result cannot be loaded.
// Reset: clears the sequencer, output valid, per-queue valid bits (empty queues, flags
// clear) and restores the default levels; the descriptor store is not cleared.
module voq_viq_pause_buffer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [vqpb_pkg::PORT_W-1:0]  in_src,
  input  logic [vqpb_pkg::PORT_W-1:0]  in_dst,
  input  logic [vqpb_pkg::DOUT_W-1:0]  in_descriptor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [vqpb_pkg::DOUT_W-1:0]  out_descriptor_out,
  output logic                         out_descriptor_valid,
  output logic                         out_voq_pause,
  output logic                         out_viq_pause,
  output logic [vqpb_pkg::OCC_W-1:0]   out_voq_occupancy,
  output logic [vqpb_pkg::OCC_W-1:0]   out_viq_occupancy,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [vqpb_pkg::LVL_W-1:0]   cfg_data
);
  import vqpb_pkg::*;

  state_t state_r, state_nxt;

  logic [LVL_W-1:0] voq_pause_lvl_r, voq_resume_lvl_r, viq_pause_lvl_r, viq_resume_lvl_r;
  logic [PIU_W-1:0] ports_r;

  // queue-state memory with per-entry valid bits; an unwritten entry reads as empty
  qent_t            qmem [QUEUES];
  logic [QUEUES-1:0] qvld_r;
  qent_t            qrd_r;
  logic [QADDR_W-1:0] q_raddr, q_raddr_r, q_waddr;
  logic             q_we;
  qent_t            q_wdata;
  qent_t            q_rent;

  // descriptor store
  logic [DESC_WIDTH-1:0] dmem [QUEUES * QUEUE_DEPTH];
  logic [DESC_WIDTH-1:0] drd_r, d_wdata;
  logic [DADDR_W-1:0]    d_waddr, d_raddr;
  logic                  d_we, d_re;

  // latched word
  logic [1:0]            kind_r;
  logic                  same_r;
  logic [PAIR_W-1:0]     pair_r;
  logic [DESC_WIDTH-1:0] desc_r;
  qent_t                 voq_e_r, viq_e_r;
  logic [PTR_W-1:0]      viq_slot_r;
  logic                  push_r;

  // result staging and output registers
  logic [2:0]       res_status_r;
  logic             res_dvalid_r, res_voq_pause_r, res_viq_pause_r;
  logic [OCC_W-1:0] res_voq_occ_r, res_viq_occ_r;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [DOUT_W-1:0] out_desc_r;
  logic             out_dvalid_r, out_voq_pause_r, out_viq_pause_r;
  logic [OCC_W-1:0] out_voq_occ_r, out_viq_occ_r;

  logic             in_acc, out_load;
  logic [PIU_W-1:0] limit;
  logic             in_range;
  logic [PAIR_W-1:0] in_pair;

  // execute-step decisions
  logic             ex_flag;
  logic [2:0]       ex_status;
  logic             ex_push, ex_pop, ex_dvalid;
  qent_t            ex_voq, ex_viq;
  qent_t            mv_viq;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign limit    = (ports_r > PIU_W'(MAX_PORTS)) ? PIU_W'(MAX_PORTS) : ports_r;
  assign in_range = (PIU_W'(in_src) < limit) && (PIU_W'(in_dst) < limit);
  assign in_pair  = PAIR_W'(PAIR_W'(in_src) * PAIR_W'(MAX_PORTS) + PAIR_W'(in_dst));

  assign q_raddr = (state_r == S_IDLE) ? {1'b0, in_pair} : {1'b1, pair_r};
  assign q_rent  = qvld_r[q_raddr_r] ? qrd_r : '0;

  // execute step: q_rent holds the VIQ entry, voq_e_r the VOQ entry
  always_comb begin
    ex_voq    = voq_e_r;
    ex_viq    = q_rent;
    ex_flag   = 1'b0;
    ex_status = ST_DONE;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_dvalid = 1'b0;
    case (kind_r)
      KIND_ENQ: begin
        ex_flag      = hyst(voq_e_r.flag, voq_e_r.cnt, voq_pause_lvl_r, voq_resume_lvl_r);
        ex_voq.flag  = ex_flag;
        if (same_r)                    ex_status = ST_SAME;
        else if (q_rent.flag)          ex_status = ST_PAUSED;
        else if (q_full(voq_e_r.cnt))  ex_status = ST_FULL;
        else begin
          ex_push     = 1'b1;
          ex_voq.tail = next_slot(voq_e_r.tail);
          ex_voq.cnt  = voq_e_r.cnt + 1'b1;
        end
      end
      KIND_XFER: begin
        ex_flag     = hyst(q_rent.flag, q_rent.cnt, viq_pause_lvl_r, viq_resume_lvl_r);
        ex_viq.flag = ex_flag;
        if (ex_flag)                    ex_status = ST_PAUSED;
        else if (same_r)                ex_status = ST_SAME;
        else if (voq_e_r.cnt == '0)     ex_status = ST_EMPTY;
        else begin
          ex_pop      = 1'b1;
          ex_voq.head = next_slot(voq_e_r.head);
          ex_voq.cnt  = voq_e_r.cnt - 1'b1;
          if (q_full(q_rent.cnt)) ex_status = ST_FULL;
          else begin
            ex_push     = 1'b1;
            ex_viq.tail = next_slot(q_rent.tail);
            ex_viq.cnt  = q_rent.cnt + 1'b1;
          end
        end
      end
      KIND_DEQ: begin
        if (q_rent.cnt == '0) ex_status = ST_EMPTY;
        else begin
          ex_dvalid   = 1'b1;
          ex_viq.head = next_slot(q_rent.head);
          ex_viq.cnt  = q_rent.cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // move step: the VIQ entry written back carries its new flag and, on a push, the
  // advanced tail (already folded in during execute)
  assign mv_viq = viq_e_r;

  // memory port steering
  always_comb begin
    q_we    = 1'b0;
    q_waddr = {1'b0, pair_r};
    q_wdata = ex_voq;
    d_we    = 1'b0;
    d_waddr = {1'b0, pair_r, voq_e_r.tail};
    d_wdata = desc_r;
    d_re    = 1'b0;
    d_raddr = {1'b0, pair_r, voq_e_r.head};
    case (state_r)
      S_EXEC: begin
        case (kind_r)
          KIND_ENQ: begin
            q_we = 1'b1;
            d_we = ex_push;
          end
          KIND_XFER: begin
            q_we = ex_pop;
            d_re = ex_pop;
          end
          KIND_DEQ: begin
            q_we    = ex_dvalid;
            q_waddr = {1'b1, pair_r};
            q_wdata = ex_viq;
            d_re    = ex_dvalid;
            d_raddr = {1'b1, pair_r, q_rent.head};
          end
          default: ;
        endcase
      end
      S_MOVE: begin
        q_we    = 1'b1;
        q_waddr = {1'b1, pair_r};
        q_wdata = mv_viq;
        d_we    = push_r;
        d_waddr = {1'b1, pair_r, viq_slot_r};
        d_wdata = drd_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = in_range ? S_RVIQ : S_OUT;
      S_RVIQ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = (kind_r == KIND_XFER) ? S_MOVE : S_OUT;
      S_MOVE: state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      qvld_r           <= '0;
      out_valid_r      <= 1'b0;
      voq_pause_lvl_r  <= LVL_W'(12);
      voq_resume_lvl_r <= LVL_W'(4);
      viq_pause_lvl_r  <= LVL_W'(12);
      viq_resume_lvl_r <= LVL_W'(4);
      ports_r          <= PIU_W'(4);
    end else begin
      state_r <= state_nxt;
      if (q_we) qvld_r[q_waddr] <= 1'b1;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOQ_PAUSE:  voq_pause_lvl_r  <= cfg_data;
          CFG_VOQ_RESUME: voq_resume_lvl_r <= cfg_data;
          CFG_VIQ_PAUSE:  viq_pause_lvl_r  <= cfg_data;
          CFG_VIQ_RESUME: viq_resume_lvl_r <= cfg_data;
          CFG_PORTS:      ports_r          <= cfg_data[PIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    qrd_r     <= qmem[q_raddr];
    q_raddr_r <= q_raddr;
    if (q_we) qmem[q_waddr] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (d_re) drd_r <= dmem[d_raddr];
    if (d_we) dmem[d_waddr] <= d_wdata;
  end

  // word and result datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      same_r <= (in_src == in_dst);
      pair_r <= in_pair;
      desc_r <= in_descriptor[DESC_WIDTH-1:0];
      if (!in_range) begin
        res_status_r    <= ST_RANGE;
        res_dvalid_r    <= 1'b0;
        res_voq_pause_r <= 1'b0;
        res_viq_pause_r <= 1'b0;
        res_voq_occ_r   <= '0;
        res_viq_occ_r   <= '0;
      end
    end
    if (state_r == S_RVIQ) voq_e_r <= q_rent;
    if (state_r == S_EXEC) begin
      // hold the VIQ entry for the move step; the push lands at its old tail
      viq_e_r         <= ex_viq;
      viq_slot_r      <= q_rent.tail;
      push_r          <= ex_push;
      res_status_r    <= ex_status;
      res_dvalid_r    <= ex_dvalid;
      res_voq_pause_r <= ex_voq.flag;
      res_viq_pause_r <= ex_viq.flag;
      res_voq_occ_r   <= OCC_W'(ex_voq.cnt);
      res_viq_occ_r   <= OCC_W'(ex_viq.cnt);
    end
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_desc_r      <= res_dvalid_r ? DOUT_W'(drd_r) : '0;
      out_dvalid_r    <= res_dvalid_r;
      out_voq_pause_r <= res_voq_pause_r;
      out_viq_pause_r <= res_viq_pause_r;
      out_voq_occ_r   <= res_voq_occ_r;
      out_viq_occ_r   <= res_viq_occ_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_descriptor_out   = out_desc_r;
  assign out_descriptor_valid = out_dvalid_r;
  assign out_voq_pause        = out_voq_pause_r;
  assign out_viq_pause        = out_viq_pause_r;
  assign out_voq_occupancy    = out_voq_occ_r;
  assign out_viq_occupancy    = out_viq_occ_r;

  a_move_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> ($past(state_r) == S_EXEC) && (kind_r == KIND_XFER))
    else $error("move step without a preceding transfer execute");

  a_dvalid_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dvalid_r) |-> (out_status_r == ST_DONE))
    else $error("popped descriptor with a non-done status");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_RANGE)) |->
      (out_voq_occ_r == '0) && (out_viq_occ_r == '0) && !out_dvalid_r)
    else $error("rejected pair reports queue state");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_voq_occ_r <= OCC_W'(QUEUE_DEPTH)) &&
                    (out_viq_occ_r <= OCC_W'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");

endmodule

/* sim/voq_viq_pause_buffer_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for voq_viq_pause_buffer: directed stimulus rows, then random
// pair-focused traffic over several register settings. Depends on vqpb_pkg and the RTL.
module voq_viq_pause_buffer_tb;
  import vqpb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]        status;
    logic [DOUT_W-1:0] desc;
    logic              desc_valid;
    logic              voq_pause;
    logic              viq_pause;
    logic [OCC_W-1:0]  voq_occ;
    logic [OCC_W-1:0]  viq_occ;
  } result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [2:0]        cfg_idx;
    logic [LVL_W-1:0]  cfg_val;
    logic [1:0]        kind;
    logic [PORT_W-1:0] src;
    logic [PORT_W-1:0] dst;
    logic [DOUT_W-1:0] desc;
    logic              typed;
    result_t           res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_kind;
  logic [PORT_W-1:0]   in_src;
  logic [PORT_W-1:0]   in_dst;
  logic [DOUT_W-1:0]   in_descriptor;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_status;
  logic [DOUT_W-1:0]   out_descriptor_out;
  logic                out_descriptor_valid;
  logic                out_voq_pause;
  logic                out_viq_pause;
  logic [OCC_W-1:0]    out_voq_occupancy;
  logic [OCC_W-1:0]    out_viq_occupancy;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [LVL_W-1:0]    cfg_data;

  // buffer state as predicted
  logic [DOUT_W-1:0] desc_mem [QUEUES][QUEUE_DEPTH];
  int                q_head [QUEUES];
  int                q_tail [QUEUES];
  int                q_occ  [QUEUES];
  bit                up_pause   [PAIRS];
  bit                xfer_pause [PAIRS];
  logic [LVL_W-1:0]  voq_pause_lvl  = 5'd12;
  logic [LVL_W-1:0]  voq_resume_lvl = 5'd4;
  logic [LVL_W-1:0]  viq_pause_lvl  = 5'd12;
  logic [LVL_W-1:0]  viq_resume_lvl = 5'd4;
  logic [PIU_W-1:0]  ports_active   = 4'd4;

  result_t   expected_results [$];
  stim_row_t stim_rows [$];
  result_t   seen_result;
  result_t   due_result;
  int        mismatch_count = 0;
  int        live_items = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;

  voq_viq_pause_buffer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_src               (in_src),
    .in_dst               (in_dst),
    .in_descriptor        (in_descriptor),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_descriptor_out   (out_descriptor_out),
    .out_descriptor_valid (out_descriptor_valid),
    .out_voq_pause        (out_voq_pause),
    .out_viq_pause        (out_viq_pause),
    .out_voq_occupancy    (out_voq_occupancy),
    .out_viq_occupancy    (out_viq_occupancy),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit next_pause(input bit flag, input int cnt,
                                    input logic [LVL_W-1:0] pause,
                                    input logic [LVL_W-1:0] resume);
    if (!flag) return cnt >= pause;
    return cnt >= resume;
  endfunction

  function automatic void push_desc(input int q, input logic [DOUT_W-1:0] d);
    desc_mem[q][q_tail[q]] = d;
    q_tail[q] = (q_tail[q] + 1) % QUEUE_DEPTH;
    q_occ[q]++;
  endfunction

  function automatic logic [DOUT_W-1:0] pop_desc(input int q);
    logic [DOUT_W-1:0] d;
    d = desc_mem[q][q_head[q]];
    q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH;
    q_occ[q]--;
    return d;
  endfunction

  function automatic result_t predict_buffer_op(input logic [1:0] kind, input int src,
                                                input int dst, input logic [DOUT_W-1:0] d);
    result_t r;
    int lim, pair, vq, iq;
    logic [DOUT_W-1:0] head_desc;
    r = '0;
    lim = (ports_active > MAX_PORTS) ? MAX_PORTS : ports_active;
    if (src >= lim || dst >= lim) begin
      r.status = ST_RANGE;
      return r;
    end
    pair = src * MAX_PORTS + dst;
    vq = pair;
    iq = PAIRS + pair;
    case (kind)
      KIND_ENQ: begin
        up_pause[pair] = next_pause(up_pause[pair], q_occ[vq], voq_pause_lvl, voq_resume_lvl);
        if (src == dst) r.status = ST_SAME;
        else if (xfer_pause[pair]) r.status = ST_PAUSED;
        else if (q_occ[vq] >= QUEUE_DEPTH) r.status = ST_FULL;
        else push_desc(vq, d);
      end
      KIND_XFER: begin
        xfer_pause[pair] = next_pause(xfer_pause[pair], q_occ[iq], viq_pause_lvl,
                                      viq_resume_lvl);
        if (xfer_pause[pair]) r.status = ST_PAUSED;
        else if (src == dst) r.status = ST_SAME;
        else if (q_occ[vq] == 0) r.status = ST_EMPTY;
        else begin
          // the head leaves the VOQ even when the VIQ cannot take it
          head_desc = pop_desc(vq);
          if (q_occ[iq] >= QUEUE_DEPTH) r.status = ST_FULL;
          else push_desc(iq, head_desc);
        end
      end
      KIND_DEQ: begin
        if (q_occ[iq] == 0) r.status = ST_EMPTY;
        else begin
          r.desc = pop_desc(iq);
          r.desc_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.voq_pause = up_pause[pair];
    r.viq_pause = xfer_pause[pair];
    r.voq_occ = OCC_W'(q_occ[vq]);
    r.viq_occ = OCC_W'(q_occ[iq]);
    return r;
  endfunction

  function automatic result_t mk_res(input logic [2:0] st, input logic [DOUT_W-1:0] d,
                                     input logic dv, input logic vp, input logic ip,
                                     input logic [OCC_W-1:0] vo, input logic [OCC_W-1:0] io);
    result_t r;
    r.status = st;
    r.desc = d;
    r.desc_valid = dv;
    r.voq_pause = vp;
    r.viq_pause = ip;
    r.voq_occ = vo;
    r.viq_occ = io;
    return r;
  endfunction

  function automatic void add_op(input logic [1:0] kind, input int src, input int dst,
                                 input logic [DOUT_W-1:0] d, input logic typed,
                                 input result_t res);
    stim_row_t row;
    row = '0;
    row.kind = kind;
    row.src = PORT_W'(src);
    row.dst = PORT_W'(dst);
    row.desc = d;
    row.typed = typed;
    row.res = res;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [LVL_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    stim_rows.push_back(row);
  endfunction

  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: want st=%0d d=%h dv=%b vp=%b ip=%b vo=%0d io=%0d | got st=%0d d=%h dv=%b vp=%b ip=%b vo=%0d io=%0d",
               $time, what, want.status, want.desc, want.desc_valid, want.voq_pause,
               want.viq_pause, want.voq_occ, want.viq_occ, got.status, got.desc,
               got.desc_valid, got.voq_pause, got.viq_pause, got.voq_occ, got.viq_occ);
  endtask

  // receiver: stall at random, sample at the rising edge
  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result = {out_status, out_descriptor_out, out_descriptor_valid, out_voq_pause,
                     out_viq_pause, out_voq_occupancy, out_viq_occupancy};
      if (expected_results.size() == 0) begin
        log_mismatch("unexpected word", '0, seen_result);
      end else begin
        due_result = expected_results.pop_front();
        if (seen_result.status !== due_result.status ||
            seen_result.desc !== due_result.desc ||
            seen_result.desc_valid !== due_result.desc_valid ||
            seen_result.voq_pause !== due_result.voq_pause ||
            seen_result.viq_pause !== due_result.viq_pause ||
            seen_result.voq_occ !== due_result.voq_occ ||
            seen_result.viq_occ !== due_result.viq_occ)
          log_mismatch("result mismatch", due_result, seen_result);
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input int src, input int dst,
                           input logic [DOUT_W-1:0] d, input logic typed,
                           input result_t typed_res);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_src = PORT_W'(src);
    in_dst = PORT_W'(dst);
    in_descriptor = d;
    do @(posedge clk); while (!in_ready);
    r = predict_buffer_op(kind, src, dst, d);
    expected_results.push_back(typed ? typed_res : r);
    if (r.status != ST_RANGE && kind != KIND_UNUSED) live_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [LVL_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_VOQ_PAUSE:  voq_pause_lvl = val;
      CFG_VOQ_RESUME: voq_resume_lvl = val;
      CFG_VIQ_PAUSE:  viq_pause_lvl = val;
      CFG_VIQ_RESUME: viq_resume_lvl = val;
      CFG_PORTS:      ports_active = val[PIU_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [LVL_W-1:0] vp, input logic [LVL_W-1:0] vr,
                                input logic [LVL_W-1:0] ip, input logic [LVL_W-1:0] ir,
                                input logic [LVL_W-1:0] ports);
    write_reg(CFG_VOQ_PAUSE, vp);
    write_reg(CFG_VOQ_RESUME, vr);
    write_reg(CFG_VIQ_PAUSE, ip);
    write_reg(CFG_VIQ_RESUME, ir);
    write_reg(CFG_PORTS, ports);
  endtask

  // bursts on one pair, of one operation or a random mix, fill and drain queues; the rest is noise
  task automatic run_traffic(input int budget);
    int start_live, sent, limit, s, d, n, op, j;
    bit held;
    logic [1:0] k;
    start_live = live_items;
    sent = 0;
    held = 1'b0;
    limit = (ports_active > MAX_PORTS) ? MAX_PORTS : ports_active;
    while (live_items - start_live < budget && sent < 4 * budget) begin
      if (!held && live_items - start_live >= budget / 2) begin
        held = 1'b1;
        wait_drained();
      end
      if (limit == 0 || $urandom_range(99) < 12) begin
        send_item(2'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
                  DOUT_W'($urandom), 1'b0, '0);
        sent++;
      end else begin
        s = $urandom_range(limit - 1);
        d = $urandom_range(limit - 1);
        if (limit > 1 && $urandom_range(7) != 0)
          while (d == s) d = $urandom_range(limit - 1);
        n = $urandom_range(1, 24);
        op = $urandom_range(4);
        for (j = 0; j < n; j++) begin
          case (op)
            0: k = KIND_ENQ;
            1: k = KIND_XFER;
            2: k = KIND_DEQ;
            default: k = 2'($urandom_range(2));
          endcase
          send_item(k, s, d, DOUT_W'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    stim_row_t row;
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ENQ;
    in_src = '0;
    in_dst = '0;
    in_descriptor = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VOQ_PAUSE;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default levels 12/4/12/4, four ports
    add_op(KIND_ENQ,  0, 1, 16'hFFFF, 1'b1, mk_res(ST_DONE,  16'h0000, 0, 0, 0, 1, 0));
    add_op(KIND_ENQ,  0, 1, 16'h0000, 1'b1, mk_res(ST_DONE,  16'h0000, 0, 0, 0, 2, 0));
    add_op(KIND_ENQ,  2, 2, 16'h1234, 1'b1, mk_res(ST_SAME,  16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_ENQ,  4, 0, 16'h4321, 1'b1, mk_res(ST_RANGE, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_ENQ,  0, 7, 16'h5555, 1'b1, mk_res(ST_RANGE, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_XFER, 7, 3, 16'h0000, 1'b1, mk_res(ST_RANGE, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_XFER, 0, 1, 16'h0000, 1'b1, mk_res(ST_DONE,  16'h0000, 0, 0, 0, 1, 1));
    add_op(KIND_DEQ,  0, 1, 16'h0000, 1'b1, mk_res(ST_DONE,  16'hFFFF, 1, 0, 0, 1, 0));
    add_op(KIND_DEQ,  0, 1, 16'h0000, 1'b1, mk_res(ST_EMPTY, 16'h0000, 0, 0, 0, 1, 0));
    add_op(KIND_XFER, 0, 0, 16'h0000, 1'b1, mk_res(ST_SAME,  16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_XFER, 1, 2, 16'h0000, 1'b1, mk_res(ST_EMPTY, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_UNUSED, 0, 1, 16'hAAAA, 1'b1, mk_res(ST_DONE, 16'h0000, 0, 0, 0, 1, 0));
    add_op(KIND_UNUSED, 7, 7, 16'hAAAA, 1'b1, mk_res(ST_RANGE, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_DEQ,  5, 1, 16'h0000, 1'b1, mk_res(ST_RANGE, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_DEQ,  3, 3, 16'h0000, 1'b1, mk_res(ST_EMPTY, 16'h0000, 0, 0, 0, 0, 0));
    add_op(KIND_XFER, 0, 1, 16'h0000, 1'b1, mk_res(ST_DONE,  16'h0000, 0, 0, 0, 0, 1));
    add_op(KIND_DEQ,  0, 1, 16'h0000, 1'b1, mk_res(ST_DONE,  16'h0000, 1, 0, 0, 0, 0));
    // low levels so that both flags set within a few words; the VIQ flag also clears again
    add_cfg(CFG_VOQ_PAUSE, 5'd2);
    add_cfg(CFG_VOQ_RESUME, 5'd1);
    add_cfg(CFG_VIQ_PAUSE, 5'd1);
    add_cfg(CFG_VIQ_RESUME, 5'd1);
    add_op(KIND_ENQ,  2, 3, 16'h1111, 1'b0, '0);
    add_op(KIND_ENQ,  2, 3, 16'h2222, 1'b0, '0);
    add_op(KIND_ENQ,  2, 3, 16'h3333, 1'b0, '0);
    add_op(KIND_XFER, 2, 3, 16'h0000, 1'b0, '0);
    add_op(KIND_XFER, 2, 3, 16'h0000, 1'b0, '0);
    add_op(KIND_ENQ,  2, 3, 16'h4444, 1'b0, '0);
    add_op(KIND_DEQ,  2, 3, 16'h0000, 1'b0, '0);
    add_op(KIND_XFER, 2, 3, 16'h0000, 1'b0, '0);
    add_op(KIND_ENQ,  2, 3, 16'h5555, 1'b0, '0);

    in_idle_pct = 37;
    out_idle_pct = 56;
    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      if (row.is_cfg) write_reg(row.cfg_idx, row.cfg_val);
      else send_item(row.kind, row.src, row.dst, row.desc, row.typed, row.res);
    end

    run_traffic(350);
    // VOQ pauses only when full and never resumes; VIQ never pauses, so transfers overflow
    apply_settings(5'd16, 5'd0, 5'd31, 5'd31, 5'd8);
    run_traffic(350);

    in_idle_pct = 56;
    out_idle_pct = 37;
    apply_settings(5'd0, 5'd0, 5'd0, 5'd0, 5'd1);
    run_traffic(60);
    // ports field keeps its low bits only, then clips to the port count
    apply_settings(5'd3, 5'd2, 5'd5, 5'd3, 5'd31);
    run_traffic(380);

    in_idle_pct = 0;
    out_idle_pct = 0;
    apply_settings(5'd8, 5'd8, 5'd8, 5'd8, 5'd0);
    run_traffic(40);
    apply_settings(5'd31, 5'd16, 5'd2, 5'd1, 5'd2);
    run_traffic(170);
    apply_settings(5'd12, 5'd4, 5'd12, 5'd4, 5'd7);
    run_traffic(400);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("voq_viq_pause_buffer_tb OK");
    end else begin
      $display("voq_viq_pause_buffer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("voq_viq_pause_buffer_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/vqpb_pkg.sv
rtl/voq_viq_pause_buffer.sv
sim/voq_viq_pause_buffer_tb.sv
